@@ rtl/core/obl_pkg.sv @@
// ----------------------------------------------------------------------------
// obl_pkg
// Shared constants, command codes and per-cell control type for the ordered
// byte list.
// ----------------------------------------------------------------------------
package obl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 3;
  localparam int VAL_W    = 8;
  localparam int POS_W    = 4;
  localparam int OCNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_SEARCH    = 3'd2,
    CMD_DELETE    = 3'd3,
    CMD_DUMP      = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_TAKE_HEAD
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_en;
    logic     active;
  } cell_ctl_t;

endpackage

@@ rtl/core/obl_cell.sv @@
// ----------------------------------------------------------------------------
// obl_cell
// One list slot: holds a byte, latches a key compare, and passes the
// first-match chain to its right neighbor.
// ----------------------------------------------------------------------------
module obl_cell (
  input  logic                      clk_i,
  input  obl_pkg::cell_ctl_t        ctl_i,
  input  logic [obl_pkg::VAL_W-1:0] key_i,
  input  logic [obl_pkg::VAL_W-1:0] new_i,
  input  logic [obl_pkg::VAL_W-1:0] left_i,
  input  logic [obl_pkg::VAL_W-1:0] right_i,
  input  logic [obl_pkg::VAL_W-1:0] head_i,
  input  logic                      seen_i,
  output logic [obl_pkg::VAL_W-1:0] data_o,
  output logic                      seen_o,
  output logic                      first_o
);
  import obl_pkg::*;

  logic [VAL_W-1:0] data_q, data_d;
  logic             match_q;
  logic             hit;

  always_comb begin
    unique case (ctl_i.op)
      CELL_HOLD:       data_d = data_q;
      CELL_LOAD:       data_d = new_i;
      CELL_TAKE_LEFT:  data_d = left_i;
      CELL_TAKE_RIGHT: data_d = right_i;
      CELL_TAKE_HEAD:  data_d = head_i;
      default:         data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctl_i.cmp_en) begin
      match_q <= (data_q == key_i);
    end
  end

  assign hit     = match_q & ctl_i.active;
  assign seen_o  = seen_i | hit;
  assign first_o = hit & ~seen_i;
  assign data_o  = data_q;

endmodule

@@ rtl/core/ordered_byte_list.sv @@
// ----------------------------------------------------------------------------
// ordered_byte_list
// Ordered list of up to CAPACITY bytes held in a chain of cells.
// ----------------------------------------------------------------------------
// Insert, search and delete pass from IDLE to EXEC and register their one
// result in EXEC; busy is high outside IDLE, so each is done before the next.
// Dump of N entries runs EXEC, then DUMP if N > 0 (at least 1 result), one
// result per cycle in DUMP, made by rotating the cell chain through the head cell.
// Reset clears the fill count and control; cell contents are left as is.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module ordered_byte_list (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [obl_pkg::CMD_W-1:0]    command_i,
  input  logic [obl_pkg::VAL_W-1:0]    value_i,
  output logic                         result_valid_o,
  output logic                         found_o,
  output logic [obl_pkg::POS_W-1:0]    position_o,
  output logic [obl_pkg::VAL_W-1:0]    entry_value_o,
  output logic                         last_o,
  output logic [obl_pkg::OCNT_W-1:0]   count_o,
  output logic                         empty_res_o,
  output logic                         overflow_o
);
  import obl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DUMP
  } state_e;

  state_e           state_q;
  logic [CMD_W-1:0] cmd_q;
  logic [VAL_W-1:0] val_q;
  logic [CNT_W-1:0] fill_q;
  logic [IDX_W-1:0] idx_q;

  logic             rv_q, found_q, last_q, empty_q, ovf_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] ev_q;
  logic [CNT_W-1:0] cnt_q;

  logic             accept;
  logic             full;
  logic             dump_last;

  cell_ctl_t        ctl   [CAPACITY];
  logic [VAL_W-1:0] data  [CAPACITY];
  logic             seen  [CAPACITY];
  logic             first [CAPACITY];
  logic [IDX_W-1:0] hit_pos;

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign full      = (fill_q == CNT_W'(CAPACITY));
  assign dump_last = ({1'b0, idx_q} + (CNT_W)'(1)) == fill_q;

  // per-cell control
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].op     = CELL_HOLD;
      ctl[i].cmp_en = accept;
      ctl[i].active = (CNT_W'(i) < fill_q);
      if (state_q == ST_EXEC) begin
        if (cmd_q == CMD_INS_FRONT && !full) begin
          ctl[i].op = (i == 0) ? CELL_LOAD : CELL_TAKE_LEFT;
        end else if (cmd_q == CMD_INS_BACK && !full) begin
          ctl[i].op = (CNT_W'(i) == fill_q) ? CELL_LOAD : CELL_HOLD;
        end else if (cmd_q == CMD_DELETE) begin
          ctl[i].op = seen[i] ? CELL_TAKE_RIGHT : CELL_HOLD;
        end
      end else if (state_q == ST_DUMP) begin
        // rotate the occupied part of the chain left by one
        if (CNT_W'(i) + CNT_W'(1) < fill_q) begin
          ctl[i].op = CELL_TAKE_RIGHT;
        end else if (CNT_W'(i) + CNT_W'(1) == fill_q) begin
          ctl[i].op = CELL_TAKE_HEAD;
        end
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    obl_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[g]),
      .key_i   (value_i),
      .new_i   (val_q),
      .left_i  ((g == 0) ? data[0] : data[(g == 0) ? 0 : g - 1]),
      .right_i ((g == CAPACITY - 1) ? data[g] : data[(g == CAPACITY - 1) ? g : g + 1]),
      .head_i  (data[0]),
      .seen_i  ((g == 0) ? 1'b0 : seen[(g == 0) ? 0 : g - 1]),
      .data_o  (data[g]),
      .seen_o  (seen[g]),
      .first_o (first[g])
    );
  end

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cmd_q   <= '0;
      val_q   <= '0;
      idx_q   <= '0;
      rv_q    <= 1'b0;
      found_q <= 1'b0;
      last_q  <= 1'b0;
      empty_q <= 1'b0;
      ovf_q   <= 1'b0;
      pos_q   <= '0;
      ev_q    <= '0;
      cnt_q   <= '0;
    end else begin
      rv_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            cmd_q   <= command_i;
            val_q   <= value_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          found_q <= 1'b0;
          pos_q   <= '0;
          ev_q    <= '0;
          last_q  <= 1'b1;
          ovf_q   <= 1'b0;
          cnt_q   <= fill_q;
          empty_q <= (fill_q == '0);
          idx_q   <= '0;
          priority if (cmd_q == CMD_INS_FRONT || cmd_q == CMD_INS_BACK) begin
            rv_q <= 1'b1;
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              fill_q  <= fill_q + CNT_W'(1);
              cnt_q   <= fill_q + CNT_W'(1);
              empty_q <= 1'b0;
            end
          end else if (cmd_q == CMD_SEARCH) begin
            rv_q    <= 1'b1;
            found_q <= seen[CAPACITY-1];
            pos_q   <= POS_W'(hit_pos);
          end else if (cmd_q == CMD_DELETE) begin
            rv_q    <= 1'b1;
            found_q <= seen[CAPACITY-1];
            pos_q   <= POS_W'(hit_pos);
            if (seen[CAPACITY-1]) begin
              fill_q  <= fill_q - CNT_W'(1);
              cnt_q   <= fill_q - CNT_W'(1);
              empty_q <= (fill_q == CNT_W'(1));
            end
          end else if (cmd_q == CMD_DUMP) begin
            if (fill_q == '0) begin
              rv_q <= 1'b1;
            end else begin
              state_q <= ST_DUMP;
            end
          end else begin
            rv_q <= 1'b0;
          end
        end
        ST_DUMP: begin
          rv_q    <= 1'b1;
          found_q <= 1'b0;
          ovf_q   <= 1'b0;
          pos_q   <= POS_W'(idx_q);
          ev_q    <= data[0];
          last_q  <= dump_last;
          cnt_q   <= fill_q;
          empty_q <= 1'b0;
          idx_q   <= idx_q + IDX_W'(1);
          if (dump_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = rv_q;
  assign found_o        = found_q;
  assign position_o     = pos_q;
  assign entry_value_o  = ev_q;
  assign last_o         = last_q;
  assign count_o        = OCNT_W'(cnt_q);
  assign empty_res_o    = empty_q;
  assign overflow_o     = ovf_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (count_o <= OCNT_W'(CAPACITY)))
    else $error("count beyond capacity");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (empty_res_o == (count_o == '0)))
    else $error("empty flag disagrees with count");

  a_ovf_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && overflow_o) |-> (!found_o && last_o))
    else $error("overflow result with found or not last");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transaction accepted without going busy");

endmodule

@@ sim/ordered_byte_list_test.sv @@
// ----------------------------------------------------------------------------
// ordered_byte_list_test
// Self-checking bench for the ordered byte list. Commands are sent one
// transaction at a time; a shadow list predicts every result, including the
// multi-result dumps, and a monitor compares each strobed result in order.
// Covers empty-list and full-list corners, then random traffic with and without gaps.
// ----------------------------------------------------------------------------
module ordered_byte_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  import obl_pkg::*;

  localparam int CMD_MAX      = (1 << CMD_W) - 1;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  entry_value;
    logic              last;
    logic [OCNT_W-1:0] count;
    logic              empty_res;
    logic              overflow;
  } list_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  command_i;
  logic [VAL_W-1:0]  value_i;
  logic              result_valid_o;
  logic              found_o;
  logic [POS_W-1:0]  position_o;
  logic [VAL_W-1:0]  entry_value_o;
  logic              last_o;
  logic [OCNT_W-1:0] count_o;
  logic              empty_res_o;
  logic              overflow_o;

  // shadow copy of the list
  logic [VAL_W-1:0]  list_cells [CAPACITY];
  int                list_fill;

  list_result_t      expected_results [$];
  int                err_cnt;
  int                stall_cycles;
  bit                gaps_on;

  ordered_byte_list u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .position_o     (position_o),
    .entry_value_o  (entry_value_o),
    .last_o         (last_o),
    .count_o        (count_o),
    .empty_res_o    (empty_res_o),
    .overflow_o     (overflow_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void queue_result(list_result_t res);
    res.count     = list_fill[OCNT_W-1:0];
    res.empty_res = (list_fill == 0);
    expected_results.push_back(res);
  endfunction

  function automatic void predict_list_op(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
    list_result_t res;
    int           hit_idx;
    res     = '0;
    hit_idx = -1;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (list_fill >= CAPACITY) begin
          res.overflow = 1'b1;
        end else begin
          if (cmd == CMD_INS_FRONT) begin
            for (int i = list_fill; i > 0; i--) list_cells[i] = list_cells[i-1];
            list_cells[0] = val;
          end else begin
            list_cells[list_fill] = val;
          end
          list_fill++;
        end
        res.last = 1'b1;
        queue_result(res);
      end
      CMD_SEARCH, CMD_DELETE: begin
        for (int i = 0; i < list_fill; i++)
          if (hit_idx < 0 && list_cells[i] == val) hit_idx = i;
        if (hit_idx >= 0) begin
          res.found    = 1'b1;
          res.position = hit_idx[POS_W-1:0];
          if (cmd == CMD_DELETE) begin
            for (int i = hit_idx; i < list_fill - 1; i++) list_cells[i] = list_cells[i+1];
            list_fill--;
          end
        end
        res.last = 1'b1;
        queue_result(res);
      end
      CMD_DUMP: begin
        if (list_fill == 0) begin
          res.last = 1'b1;
          queue_result(res);
        end else begin
          for (int i = 0; i < list_fill; i++) begin
            res             = '0;
            res.position    = i[POS_W-1:0];
            res.entry_value = list_cells[i];
            res.last        = (i == list_fill - 1);
            queue_result(res);
          end
        end
      end
      default: begin
        // reserved codes produce nothing
      end
    endcase
  endfunction

  function automatic void note_mismatch(string what, list_result_t want, list_result_t got);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%0t ERROR %s: exp found=%0d pos=%0d val=%02h last=%0d cnt=%0d empty=%0d ovf=%0d",
               $realtime, what, want.found, want.position, want.entry_value, want.last,
               want.count, want.empty_res, want.overflow);
    if (err_cnt <= 10)
      $display("          got found=%0d pos=%0d val=%02h last=%0d cnt=%0d empty=%0d ovf=%0d",
               got.found, got.position, got.entry_value, got.last, got.count,
               got.empty_res, got.overflow);
  endfunction

  // result monitor: strobe is sampled at the edge that ends its cycle
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (rst_ni && result_valid_o) begin
      got = {found_o, position_o, entry_value_o, last_o, count_o, empty_res_o, overflow_o};
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.found !== want.found || got.position !== want.position ||
            got.entry_value !== want.entry_value || got.last !== want.last ||
            got.count !== want.count || got.empty_res !== want.empty_res ||
            got.overflow !== want.overflow)
          note_mismatch("result mismatch", want, got);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((rst_ni && start && !busy) || (rst_ni && result_valid_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t ERROR watchdog expired, %0d results outstanding",
               $realtime, expected_results.size());
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Called at a rising edge; returns at the accepting edge, or after a gap.
  // start is left high so back-to-back commands need no extra edge.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
    start     <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    predict_list_op(cmd, val);
    if (gaps_on && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] pick_value(int hit_pct);
    int r;
    r = $urandom_range(0, 99);
    if (list_fill > 0 && r < hit_pct) return list_cells[$urandom_range(0, list_fill - 1)];
    // a small pool makes duplicates common
    if (r % 2 == 0) return VAL_W'($urandom_range(0, 3));
    return VAL_W'($urandom_range(0, 255));
  endfunction

  task automatic test_empty_list();
    send_command(CMD_DUMP, 8'h00);
    send_command(CMD_SEARCH, 8'hFF);
    send_command(CMD_DELETE, 8'h00);
    send_command(CMD_W'(CMD_MAX), 8'hFF);
  endtask

  task automatic test_fill_to_capacity();
    send_command(CMD_INS_BACK, 8'h00);
    send_command(CMD_INS_BACK, 8'hFF);
    send_command(CMD_INS_FRONT, 8'h5A);
    send_command(CMD_INS_FRONT, 8'hA5);
    send_command(CMD_INS_BACK, 8'h5A);
    for (int i = 0; i < CAPACITY - 5; i++)
      send_command(i[0] ? CMD_INS_FRONT : CMD_INS_BACK, VAL_W'(8'h10 + i));
    // full list refuses both inserts
    send_command(CMD_INS_FRONT, 8'h77);
    send_command(CMD_INS_BACK, 8'h88);
    send_command(CMD_DUMP, 8'h00);
    // duplicate: first occurrence from the front wins
    send_command(CMD_SEARCH, 8'h5A);
    send_command(CMD_DELETE, 8'h5A);
  endtask

  task automatic test_random_traffic(int n_items, bit with_gaps, int insert_pct);
    int               sent;
    int               r;
    int               span;
    int               rest;
    logic [CMD_W-1:0] cmd;
    sent    = 0;
    gaps_on = with_gaps;
    span    = 100 - insert_pct;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        cmd = $urandom_range(0, 1) ? CMD_INS_FRONT : CMD_INS_BACK;
        send_command(cmd, pick_value(20));
        sent++;
      end else begin
        rest = r - insert_pct;
        if (rest < span * 4 / 10) begin
          send_command(CMD_DELETE, pick_value(75));
          sent++;
        end else if (rest < span * 7 / 10) begin
          send_command(CMD_SEARCH, pick_value(60));
          sent++;
        end else if (rest < span * 9 / 10) begin
          send_command(CMD_DUMP, VAL_W'($urandom_range(0, 255)));
          sent++;
        end else begin
          cmd = CMD_W'($urandom_range(CMD_DUMP + 1, CMD_MAX));
          send_command(cmd, VAL_W'($urandom_range(0, 255)));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    command_i    = '0;
    value_i      = '0;
    err_cnt      = 0;
    stall_cycles = 0;
    list_fill    = 0;
    gaps_on      = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_fill_to_capacity();
    test_random_traffic(60, 1'b1, 35);
    wait_results_drained();
    test_random_traffic(60, 1'b0, 65);
    test_random_traffic(80, 1'b1, 50);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      err_cnt++;
      $display("ERROR %0d expected results never arrived", expected_results.size());
    end
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/obl_pkg.sv
rtl/core/obl_cell.sv
rtl/core/ordered_byte_list.sv
sim/ordered_byte_list_test.sv
